### rtl/isfp_pkg.sv
// shared types and constants for the imu serial frame parser
// no dependencies; compiled first
package isfp_pkg;

    // field widths
    localparam int BYTE_W     = 8;
    localparam int STATUS_W   = 3;
    localparam int VAL_W      = 27;
    localparam int WORD_W     = 16;
    localparam int FAC_W      = 11;
    localparam int ACCEL_W    = 5;
    localparam int LEN_W      = 4;
    localparam int NUM_VALS   = 6;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 11;

    // frame bytes
    localparam logic [BYTE_W-1:0] HDR_BYTE = 8'h55;
    localparam logic [BYTE_W-1:0] ID_ANGLE = 8'h01;
    localparam logic [BYTE_W-1:0] ID_IMU   = 8'h03;

    // fixed scale for angle words
    localparam logic [FAC_W-1:0] ANGLE_SCALE = 11'd180;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_FS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_GYRO_FS  = 1'b1;

    // configuration reset values
    localparam logic [ACCEL_W-1:0] ACCEL_FS_RST = 5'd16;
    localparam logic [FAC_W-1:0]   GYRO_FS_RST  = 11'd2000;

    // frame status codes
    localparam logic [STATUS_W-1:0] STAT_ANGLE = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_IMU   = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_OTHER = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_CKSUM = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_BADID = 3'd4;

    // parser phases
    typedef enum logic [2:0] {
        PH_HUNT1 = 3'd0,
        PH_HUNT2 = 3'd1,
        PH_ID    = 3'd2,
        PH_LEN   = 3'd3,
        PH_DATA  = 3'd4,
        PH_SUM   = 3'd5
    } t_phase;

    // expected payload length per id, zero for unknown ids
    function automatic logic [LEN_W-1:0] table_length(input logic [BYTE_W-1:0] id);
        logic [LEN_W-1:0] n;
        unique case (id)
            8'h01:   n = 4'd6;
            8'h02:   n = 4'd8;
            8'h03:   n = 4'd12;
            8'h04:   n = 4'd8;
            8'h05:   n = 4'd10;
            8'h06:   n = 4'd8;
            default: n = 4'd0;
        endcase
        return n;
    endfunction

endpackage

### rtl/isfp_rx_if.sv
// received byte channel: valid, ready and one serial byte
// depends on isfp_pkg
interface isfp_rx_if;
    logic                         valid;
    logic                         ready;
    logic [isfp_pkg::BYTE_W-1:0]  rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

### rtl/isfp_res_if.sv
// frame result channel: valid, ready, status, id and six scaled values
// depends on isfp_pkg
interface isfp_res_if;
    logic                                valid;
    logic                                ready;
    logic [isfp_pkg::STATUS_W-1:0]       frame_status;
    logic [isfp_pkg::BYTE_W-1:0]         frame_kind;
    logic signed [isfp_pkg::VAL_W-1:0]   value_a;
    logic signed [isfp_pkg::VAL_W-1:0]   value_b;
    logic signed [isfp_pkg::VAL_W-1:0]   value_c;
    logic signed [isfp_pkg::VAL_W-1:0]   value_d;
    logic signed [isfp_pkg::VAL_W-1:0]   value_e;
    logic signed [isfp_pkg::VAL_W-1:0]   value_f;

    modport source (output valid, output frame_status, output frame_kind,
                    output value_a, output value_b, output value_c,
                    output value_d, output value_e, output value_f,
                    input ready);
    modport sink   (input valid, input frame_status, input frame_kind,
                    input value_a, input value_b, input value_c,
                    input value_d, input value_e, input value_f,
                    output ready);
endinterface

### rtl/isfp_cfg_if.sv
// configuration write channel: valid, ready, register index and data
// depends on isfp_pkg
interface isfp_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [isfp_pkg::CFG_IDX_W-1:0]    index;
    logic [isfp_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/isfp_scaler.sv
// six parallel signed word by unsigned factor multipliers
// depends on isfp_pkg
module isfp_scaler (
    input  logic signed [isfp_pkg::WORD_W-1:0] i_word [isfp_pkg::NUM_VALS],
    input  logic        [isfp_pkg::FAC_W-1:0]  i_fac_abc,
    input  logic        [isfp_pkg::FAC_W-1:0]  i_fac_def,
    output logic signed [isfp_pkg::VAL_W-1:0]  o_val [isfp_pkg::NUM_VALS]
);
    import isfp_pkg::*;

    // first three words take the angle/accel factor, last three the gyro factor
    for (genvar k = 0; k < NUM_VALS; k++) begin : g_mul
        logic signed [VAL_W-1:0] word_ext;
        logic signed [VAL_W-1:0] fac_ext;

        assign word_ext = VAL_W'(i_word[k]);
        assign fac_ext  = $signed(VAL_W'((k < NUM_VALS / 2) ? i_fac_abc : i_fac_def));
        assign o_val[k] = VAL_W'(word_ext * fac_ext);
    end

endmodule

### rtl/imu_serial_frame_parser.sv
// imu serial frame parser top level: header hunt, length and checksum check,
// payload capture and scaled result register
// depends on isfp_pkg, isfp_rx_if, isfp_res_if, isfp_cfg_if, isfp_scaler
//
// usage
//   i_rx carries one received serial byte per transfer. o_res carries one
//   result per frame end: a status, the id byte and six scaled values.
//   i_cfg writes accel full scale (index 0) and gyro full scale (index 1);
//   it is always ready and should be written only while the parser is idle.
// latency and throughput
//   one byte per cycle while i_rx.ready is high. The result for a frame
//   appears on o_res the cycle after its final byte (checksum, or a bad
//   length byte) is transferred. All decoding and the six scale multiplies
//   sit between the state registers and the result register.
// reset
//   synchronous, active low: parser returns to hunting the first header
//   byte, result register empties, full scale registers load 16 and 2000.
// stall
//   while a result waits on o_res, bytes that cannot end a frame are still
//   taken; i_rx.ready drops only for a byte that could end a frame.
module imu_serial_frame_parser #(
    parameter int MAX_PAYLOAD = 12
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    isfp_rx_if.sink           i_rx,
    isfp_res_if.source        o_res,
    isfp_cfg_if.sink          i_cfg
);
    import isfp_pkg::*;

    localparam int IDX_W = $clog2(MAX_PAYLOAD);
    localparam int CNT_W = LEN_W + 1;

    // parser state
    t_phase                  r_phase;
    t_phase                  n_phase;
    logic [BYTE_W-1:0]       r_id;
    logic [LEN_W-1:0]        r_len;
    logic [LEN_W-1:0]        r_count;
    logic [BYTE_W-1:0]       r_sum;
    logic [BYTE_W-1:0]       r_store [MAX_PAYLOAD];

    // configuration
    logic [ACCEL_W-1:0]      r_accel_fs;
    logic [FAC_W-1:0]        r_gyro_fs;

    // result register
    logic                    r_out_valid;
    logic [STATUS_W-1:0]     r_status;
    logic [BYTE_W-1:0]       r_kind;
    logic signed [VAL_W-1:0] r_val [NUM_VALS];

    logic                    rx_fire;
    logic                    res_free;
    logic [BYTE_W-1:0]       b;
    logic [LEN_W-1:0]        want;
    logic                    len_ok;
    logic [LEN_W-1:0]        count_inc;
    logic                    emit;
    logic [STATUS_W-1:0]     emit_status;
    logic signed [WORD_W-1:0] word [NUM_VALS];
    logic signed [VAL_W-1:0]  scaled [NUM_VALS];
    logic [FAC_W-1:0]        fac_abc;

    assign b        = i_rx.rx_byte;
    assign res_free = !r_out_valid || o_res.ready;
    assign i_rx.ready = res_free || !(r_phase == PH_LEN || r_phase == PH_SUM);
    assign rx_fire  = i_rx.valid && i_rx.ready;
    assign i_cfg.ready = 1'b1;

    // length check against the per-id table
    assign want   = table_length(r_id);
    assign len_ok = (want != '0) && (CNT_W'(want) <= CNT_W'(MAX_PAYLOAD))
                    && (b == BYTE_W'(want));
    assign count_inc = r_count + LEN_W'(1);

    // next phase
    always_comb begin
        n_phase = r_phase;
        if (rx_fire) begin
            unique case (r_phase)
                PH_HUNT1: n_phase = (b == HDR_BYTE) ? PH_HUNT2 : PH_HUNT1;
                PH_HUNT2: n_phase = (b == HDR_BYTE) ? PH_ID : PH_HUNT1;
                PH_ID:    n_phase = PH_LEN;
                PH_LEN:   n_phase = len_ok ? PH_DATA : PH_HUNT1;
                PH_DATA:  n_phase = (count_inc >= r_len) ? PH_SUM : PH_DATA;
                PH_SUM:   n_phase = PH_HUNT1;
                default:  n_phase = PH_HUNT1;
            endcase
        end
    end

    // result strobe and status
    always_comb begin
        emit        = 1'b0;
        emit_status = STAT_OTHER;
        unique case (r_phase)
            PH_LEN: begin
                emit        = rx_fire && !len_ok;
                emit_status = STAT_BADID;
            end
            PH_SUM: begin
                emit = rx_fire;
                if (b != r_sum) begin
                    emit_status = STAT_CKSUM;
                end else if (r_id == ID_ANGLE) begin
                    emit_status = STAT_ANGLE;
                end else if (r_id == ID_IMU) begin
                    emit_status = STAT_IMU;
                end else begin
                    emit_status = STAT_OTHER;
                end
            end
            default: begin
                emit        = 1'b0;
                emit_status = STAT_OTHER;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT1;
        end else begin
            r_phase <= n_phase;
        end
    end

    // frame bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_id    <= '0;
            r_len   <= '0;
            r_count <= '0;
            r_sum   <= '0;
        end else if (rx_fire) begin
            if (r_phase == PH_ID) begin
                r_id <= b;
            end
            if (r_phase == PH_LEN && len_ok) begin
                r_len   <= LEN_W'(b);
                r_count <= '0;
                r_sum   <= HDR_BYTE + HDR_BYTE + r_id + b;
            end
            if (r_phase == PH_DATA) begin
                r_sum   <= r_sum + b;
                r_count <= count_inc;
            end
        end
    end

    // payload capture
    always_ff @(posedge i_clk) begin
        if (rx_fire && r_phase == PH_DATA && CNT_W'(r_count) < CNT_W'(MAX_PAYLOAD)) begin
            r_store[r_count[IDX_W-1:0]] <= b;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accel_fs <= ACCEL_FS_RST;
            r_gyro_fs  <= GYRO_FS_RST;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.index)
                REG_ACCEL_FS: r_accel_fs <= i_cfg.data[ACCEL_W-1:0];
                REG_GYRO_FS:  r_gyro_fs  <= i_cfg.data[FAC_W-1:0];
                default:      r_gyro_fs  <= r_gyro_fs;
            endcase
        end
    end

    // little-endian words from the payload, zero past the store
    for (genvar k = 0; k < NUM_VALS; k++) begin : g_word
        if (2 * k + 1 < MAX_PAYLOAD) begin : g_in
            assign word[k] = $signed({r_store[2*k+1], r_store[2*k]});
        end else begin : g_out
            assign word[k] = '0;
        end
    end

    assign fac_abc = (r_id == ID_ANGLE) ? ANGLE_SCALE : FAC_W'(r_accel_fs);

    isfp_scaler u_scaler (
        .i_word    (word),
        .i_fac_abc (fac_abc),
        .i_fac_def (r_gyro_fs),
        .o_val     (scaled)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_status <= emit_status;
            r_kind   <= r_id;
            for (int k = 0; k < NUM_VALS; k++) begin
                if (emit_status == STAT_IMU) begin
                    r_val[k] <= scaled[k];
                end else if (emit_status == STAT_ANGLE && k < NUM_VALS / 2) begin
                    r_val[k] <= scaled[k];
                end else begin
                    r_val[k] <= '0;
                end
            end
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.frame_status = r_status;
    assign o_res.frame_kind   = r_kind;
    assign o_res.value_a      = r_val[0];
    assign o_res.value_b      = r_val[1];
    assign o_res.value_c      = r_val[2];
    assign o_res.value_d      = r_val[3];
    assign o_res.value_e      = r_val[4];
    assign o_res.value_f      = r_val[5];

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps
// testbench for imu_serial_frame_parser: drives serial byte streams, predicts each
// frame result in step with the accepted bytes and checks every result transfer
// depends on isfp_pkg, isfp_rx_if, isfp_res_if, isfp_cfg_if and the rtl top level
module testbench;
    import isfp_pkg::*;

    localparam int PAYLOAD_MAX   = 12;
    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 4;
    localparam int HOLD_CYCLES   = 300;
    localparam int PRINT_LIMIT   = 50;

    // ids with a fixed length but no decoded values, an unknown id, and the fill byte
    localparam logic [BYTE_W-1:0] ID_AUX2   = 8'h02;
    localparam logic [BYTE_W-1:0] ID_AUX4   = 8'h04;
    localparam logic [BYTE_W-1:0] ID_AUX5   = 8'h05;
    localparam logic [BYTE_W-1:0] ID_AUX6   = 8'h06;
    localparam logic [BYTE_W-1:0] ID_NONE   = 8'h00;
    localparam logic [BYTE_W-1:0] FILL_BYTE = 8'h00;

    typedef logic [BYTE_W-1:0] t_bytes [$];

    typedef struct packed {
        logic [STATUS_W-1:0]     status;
        logic [BYTE_W-1:0]       kind;
        logic signed [VAL_W-1:0] val_a;
        logic signed [VAL_W-1:0] val_b;
        logic signed [VAL_W-1:0] val_c;
        logic signed [VAL_W-1:0] val_d;
        logic signed [VAL_W-1:0] val_e;
        logic signed [VAL_W-1:0] val_f;
    } t_frame_result;

    logic i_clk;
    logic i_rst_n;

    isfp_rx_if  rx_ch ();
    isfp_res_if res_ch ();
    isfp_cfg_if cfg_ch ();

    imu_serial_frame_parser i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_ch),
        .o_res   (res_ch),
        .i_cfg   (cfg_ch)
    );

    // predictor state, mirrors the parser
    t_phase            rx_phase;
    logic [BYTE_W-1:0] frame_id;
    logic [LEN_W-1:0]  frame_len;
    logic [4:0]        data_count;
    logic [BYTE_W-1:0] check_sum;
    logic [BYTE_W-1:0] payload_bytes [PAYLOAD_MAX];
    logic [ACCEL_W-1:0] accel_scale;
    logic [FAC_W-1:0]   gyro_scale;

    t_frame_result pending_results [$];

    int err_count     = 0;
    int bytes_sent    = 0;
    int results_seen  = 0;
    int idle_cycles   = 0;
    int hold_request  = 0;
    int status_seen [8];
    bit src_idle_on   = 1'b0;
    bit sink_idle_on  = 1'b0;

    // clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // expected payload length for an id, zero when the id is not known
    function automatic int frame_length_for(input logic [BYTE_W-1:0] id);
        int n;
        case (id)
            ID_ANGLE: n = 6;
            ID_AUX2:  n = 8;
            ID_IMU:   n = 12;
            ID_AUX4:  n = 8;
            ID_AUX5:  n = 10;
            ID_AUX6:  n = 8;
            default:  n = 0;
        endcase
        if (n > PAYLOAD_MAX)
            n = 0;
        return n;
    endfunction

    // little-endian signed word k times a scale, wrapped to the value width
    function automatic logic signed [VAL_W-1:0] scaled_word(input int k, input int factor);
        logic signed [WORD_W-1:0] w;
        int p;
        w = {payload_bytes[2*k+1], payload_bytes[2*k]};
        p = int'(w) * factor;
        return p[VAL_W-1:0];
    endfunction

    // advance the frame predictor by one accepted byte; 1 when a frame ends
    function automatic bit predict_frame_byte(input logic [BYTE_W-1:0] b,
                                              output t_frame_result r);
        int want;
        bit done;
        r = '0;
        done = 1'b0;
        case (rx_phase)
            PH_HUNT1: begin
                if (b == HDR_BYTE)
                    rx_phase = PH_HUNT2;
            end
            PH_HUNT2: rx_phase = (b == HDR_BYTE) ? PH_ID : PH_HUNT1;
            PH_ID: begin
                frame_id = b;
                rx_phase = PH_LEN;
            end
            PH_LEN: begin
                want = frame_length_for(frame_id);
                if (want == 0 || int'(b) != want) begin
                    r.status = STAT_BADID;
                    r.kind = frame_id;
                    rx_phase = PH_HUNT1;
                    done = 1'b1;
                end else begin
                    frame_len = b[LEN_W-1:0];
                    data_count = '0;
                    check_sum = HDR_BYTE + HDR_BYTE + frame_id + b;
                    rx_phase = PH_DATA;
                end
            end
            PH_DATA: begin
                if (data_count < PAYLOAD_MAX)
                    payload_bytes[data_count[LEN_W-1:0]] = b;
                check_sum = check_sum + b;
                data_count = data_count + 1'b1;
                if (data_count >= frame_len)
                    rx_phase = PH_SUM;
            end
            PH_SUM: begin
                r.kind = frame_id;
                rx_phase = PH_HUNT1;
                done = 1'b1;
                if (b != check_sum) begin
                    r.status = STAT_CKSUM;
                end else if (frame_id == ID_ANGLE) begin
                    r.status = STAT_ANGLE;
                    r.val_a = scaled_word(0, int'(ANGLE_SCALE));
                    r.val_b = scaled_word(1, int'(ANGLE_SCALE));
                    r.val_c = scaled_word(2, int'(ANGLE_SCALE));
                end else if (frame_id == ID_IMU) begin
                    r.status = STAT_IMU;
                    r.val_a = scaled_word(0, int'(accel_scale));
                    r.val_b = scaled_word(1, int'(accel_scale));
                    r.val_c = scaled_word(2, int'(accel_scale));
                    r.val_d = scaled_word(3, int'(gyro_scale));
                    r.val_e = scaled_word(4, int'(gyro_scale));
                    r.val_f = scaled_word(5, int'(gyro_scale));
                end else begin
                    r.status = STAT_OTHER;
                end
            end
            default: rx_phase = PH_HUNT1;
        endcase
        return done;
    endfunction

    // random payload, with the sign and range extremes of a byte mixed in
    function automatic t_bytes random_payload(input int n);
        t_bytes q;
        int i;
        for (i = 0; i < n; i++) begin
            if ($urandom_range(0, 3) == 0) begin
                case ($urandom_range(0, 3))
                    0:       q.push_back(8'h00);
                    1:       q.push_back(8'h7F);
                    2:       q.push_back(8'h80);
                    default: q.push_back(8'hFF);
                endcase
            end else begin
                q.push_back(8'($urandom_range(0, 255)));
            end
        end
        return q;
    endfunction

    // payload from 16-bit words, word 0 in the low bits
    function automatic t_bytes word_payload(input logic [6*WORD_W-1:0] words, input int count);
        t_bytes q;
        int k;
        for (k = 0; k < count; k++) begin
            q.push_back(words[WORD_W*k +: 8]);
            q.push_back(words[WORD_W*k+8 +: 8]);
        end
        return q;
    endfunction

    function automatic logic [BYTE_W-1:0] random_known_id();
        case ($urandom_range(0, 9))
            0, 1, 2: return ID_ANGLE;
            3, 4, 5: return ID_IMU;
            6:       return ID_AUX2;
            7:       return ID_AUX4;
            8:       return ID_AUX5;
            default: return ID_AUX6;
        endcase
    endfunction

    task automatic report_mismatch(input string what);
        if (err_count < PRINT_LIMIT)
            $display("MISMATCH at %0t: %s", $time, what);
        err_count++;
    endtask

    task automatic check_field(input string name, input logic [VAL_W-1:0] got,
                               input logic [VAL_W-1:0] want, input logic [BYTE_W-1:0] kind);
        if (got !== want)
            report_mismatch($sformatf("%s got %h want %h (frame id %02h)", name, got, want, kind));
    endtask

    // one byte transfer on the receive channel, then predict its effect
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        t_frame_result r;
        if (src_idle_on && $urandom_range(0, 7) == 0) begin
            rx_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        rx_ch.valid <= 1'b1;
        rx_ch.rx_byte <= b;
        @(posedge i_clk);
        while (rx_ch.ready !== 1'b1)
            @(posedge i_clk);
        bytes_sent++;
        if (predict_frame_byte(b, r))
            pending_results.push_back(r);
    endtask

    // header, id, length; payload and checksum only when the length is right
    task automatic send_frame(input logic [BYTE_W-1:0] id, input logic [BYTE_W-1:0] len_byte,
                              input t_bytes body, input bit bad_sum);
        logic [BYTE_W-1:0] sum;
        int want;
        want = frame_length_for(id);
        sum = HDR_BYTE + HDR_BYTE + id + len_byte;
        send_byte(HDR_BYTE);
        send_byte(HDR_BYTE);
        send_byte(id);
        send_byte(len_byte);
        if (want != 0 && int'(len_byte) == want) begin
            foreach (body[i]) begin
                send_byte(body[i]);
                sum = sum + body[i];
            end
            if (bad_sum)
                sum = sum ^ (8'h01 << $urandom_range(0, 7));
            send_byte(sum);
        end
    endtask

    // zero bytes until the parser is back to hunting
    task automatic drain_parser();
        while (rx_phase != PH_HUNT1)
            send_byte(FILL_BYTE);
    endtask

    // stop offering bytes and let every pending result come out
    task automatic wait_results();
        rx_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // both full scale registers, one transfer each
    task automatic write_config(input logic [CFG_DATA_W-1:0] accel_data,
                                input logic [CFG_DATA_W-1:0] gyro_data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= REG_ACCEL_FS;
        cfg_ch.data <= accel_data;
        @(posedge i_clk);
        while (cfg_ch.ready !== 1'b1)
            @(posedge i_clk);
        accel_scale = accel_data[ACCEL_W-1:0];
        cfg_ch.index <= REG_GYRO_FS;
        cfg_ch.data <= gyro_data;
        @(posedge i_clk);
        while (cfg_ch.ready !== 1'b1)
            @(posedge i_clk);
        gyro_scale = gyro_data;
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // every id, word extremes, checksum and length errors, header breaks
    task automatic test_directed_frames();
        t_bytes no_body;
        send_frame(ID_ANGLE, BYTE_W'(frame_length_for(ID_ANGLE)),
                   word_payload({16'h0, 16'h0, 16'h0, 16'h0000, 16'h7FFF, 16'h8000}, 3), 1'b0);
        send_frame(ID_IMU, BYTE_W'(frame_length_for(ID_IMU)),
                   word_payload({16'h7FFF, 16'h8000, 16'h0001, 16'hFFFF, 16'h7FFF, 16'h8000}, 6),
                   1'b0);
        send_frame(ID_AUX2, BYTE_W'(frame_length_for(ID_AUX2)), random_payload(8), 1'b0);
        send_frame(ID_AUX4, BYTE_W'(frame_length_for(ID_AUX4)), random_payload(8), 1'b0);
        send_frame(ID_AUX5, BYTE_W'(frame_length_for(ID_AUX5)), random_payload(10), 1'b0);
        send_frame(ID_AUX6, BYTE_W'(frame_length_for(ID_AUX6)), random_payload(8), 1'b0);
        // checksum errors
        send_frame(ID_ANGLE, BYTE_W'(frame_length_for(ID_ANGLE)), random_payload(6), 1'b1);
        send_frame(ID_IMU, BYTE_W'(frame_length_for(ID_IMU)), random_payload(12), 1'b1);
        // unknown ids and wrong lengths end at the length byte
        send_frame(ID_NONE, 8'h00, no_body, 1'b0);
        send_frame(8'hFF, 8'hFF, no_body, 1'b0);
        send_frame(ID_IMU, 8'h0B, no_body, 1'b0);
        send_frame(ID_ANGLE, 8'hFF, no_body, 1'b0);
        // broken header, then a good frame right after
        send_byte(HDR_BYTE);
        send_byte(8'hAA);
        send_frame(ID_ANGLE, BYTE_W'(frame_length_for(ID_ANGLE)), random_payload(6), 1'b0);
        // a run of header bytes: the third becomes the id and fails the table
        repeat (4) send_byte(HDR_BYTE);
        wait_results();
    endtask

    // full scale registers at their limits and out of range
    task automatic test_scale_extremes();
        logic [CFG_DATA_W-1:0] accel_data, gyro_data;
        int i;
        for (i = 0; i < 5; i++) begin
            case (i)
                0:       begin accel_data = 11'd1;    gyro_data = 11'd1;    end
                1:       begin accel_data = 11'd0;    gyro_data = 11'd0;    end
                2:       begin accel_data = 11'h01F;  gyro_data = 11'h7FF;  end
                3:       begin accel_data = 11'h7E1;  gyro_data = 11'd1000; end
                default: begin accel_data = 11'd16;   gyro_data = 11'd2000; end
            endcase
            write_config(accel_data, gyro_data);
            send_frame(ID_IMU, BYTE_W'(frame_length_for(ID_IMU)),
                       word_payload({16'h8000, 16'h7FFF, 16'hFFFF, 16'h8000, 16'h7FFF, 16'h8000},
                                    6), 1'b0);
            send_frame(ID_IMU, BYTE_W'(frame_length_for(ID_IMU)), random_payload(12), 1'b0);
            send_frame(ID_ANGLE, BYTE_W'(frame_length_for(ID_ANGLE)), random_payload(6), 1'b0);
            wait_results();
        end
    endtask

    // long result hold-off while frames keep coming, so the input stalls
    task automatic test_output_backpressure();
        int i;
        hold_request = HOLD_CYCLES;
        for (i = 0; i < 6; i++) begin
            if (i[0])
                send_frame(ID_IMU, BYTE_W'(frame_length_for(ID_IMU)), random_payload(12), 1'b0);
            else
                send_frame(ID_ANGLE, BYTE_W'(frame_length_for(ID_ANGLE)), random_payload(6),
                           1'b0);
        end
        wait_results();
    endtask

    // mostly good frames with random content, plus errors and line noise
    task automatic test_random_stream(input int nbytes, input logic [CFG_DATA_W-1:0] accel_data,
                                      input logic [CFG_DATA_W-1:0] gyro_data);
        int stop_at, pick, n, k;
        logic [BYTE_W-1:0] id, len;
        t_bytes no_body;
        write_config(accel_data, gyro_data);
        stop_at = bytes_sent + nbytes;
        while (bytes_sent < stop_at) begin
            pick = $urandom_range(0, 99);
            id = random_known_id();
            n = frame_length_for(id);
            if (pick < 62) begin
                send_frame(id, BYTE_W'(n), random_payload(n), 1'b0);
            end else if (pick < 72) begin
                send_frame(id, BYTE_W'(n), random_payload(n), 1'b1);
            end else if (pick < 80) begin
                len = $urandom_range(0, 1) ? BYTE_W'(n + 1) : BYTE_W'($urandom_range(0, 255));
                while (int'(len) == n)
                    len = BYTE_W'($urandom_range(0, 255));
                send_frame(id, len, no_body, 1'b0);
            end else if (pick < 86) begin
                id = BYTE_W'($urandom_range(0, 255));
                while (frame_length_for(id) != 0)
                    id = BYTE_W'($urandom_range(0, 255));
                send_frame(id, BYTE_W'($urandom_range(0, 255)), no_body, 1'b0);
            end else if (pick < 92) begin
                send_byte(HDR_BYTE);
                len = BYTE_W'($urandom_range(0, 255));
                while (len == HDR_BYTE)
                    len = BYTE_W'($urandom_range(0, 255));
                send_byte(len);
            end else begin
                // noise with header bytes mixed in, then back to hunting
                n = $urandom_range(1, 10);
                for (k = 0; k < n; k++)
                    send_byte(($urandom_range(0, 3) == 0) ? HDR_BYTE : 8'($urandom_range(0, 255)));
                drain_parser();
            end
        end
        wait_results();
    endtask

    // result receiver: random short stalls, or one long hold when asked
    initial begin : result_sink
        int gap;
        res_ch.ready = 1'b1;
        forever begin
            @(posedge i_clk);
            if (hold_request > 0) begin
                gap = hold_request;
                res_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
                hold_request = 0;
                res_ch.ready <= 1'b1;
            end else if (sink_idle_on && $urandom_range(0, 9) == 0) begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
                res_ch.ready <= 1'b1;
            end
        end
    end

    // compare each result transfer with the oldest predicted frame
    always @(posedge i_clk) begin : result_check
        t_frame_result want;
        int errs_at_start;
        if (i_rst_n && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("result with no frame pending, id %02h",
                                          res_ch.frame_kind));
            end else begin
                want = pending_results.pop_front();
                errs_at_start = err_count;
                check_field("frame_status", res_ch.frame_status, want.status, want.kind);
                check_field("frame_kind", res_ch.frame_kind, want.kind, want.kind);
                check_field("value_a", res_ch.value_a, want.val_a, want.kind);
                check_field("value_b", res_ch.value_b, want.val_b, want.kind);
                check_field("value_c", res_ch.value_c, want.val_c, want.kind);
                check_field("value_d", res_ch.value_d, want.val_d, want.kind);
                check_field("value_e", res_ch.value_e, want.val_e, want.kind);
                check_field("value_f", res_ch.value_f, want.val_f, want.kind);
                if (err_count == errs_at_start)
                    status_seen[want.status]++;
            end
        end
    end

    // watchdog on cycles with no transfer on any channel
    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (rx_ch.valid === 1'b1 && rx_ch.ready === 1'b1) ||
            (res_ch.valid === 1'b1 && res_ch.ready === 1'b1) ||
            (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
            $display("imu_serial_frame_parser test failed");
            $finish;
        end
    end

    // test sequence
    initial begin
        int i;
        rx_ch.valid = 1'b0;
        rx_ch.rx_byte = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = REG_ACCEL_FS;
        cfg_ch.data = '0;
        i_rst_n = 1'b0;
        rx_phase = PH_HUNT1;
        frame_id = '0;
        frame_len = '0;
        data_count = '0;
        check_sum = '0;
        for (i = 0; i < PAYLOAD_MAX; i++)
            payload_bytes[i] = '0;
        for (i = 0; i < 8; i++)
            status_seen[i] = 0;
        accel_scale = ACCEL_FS_RST;
        gyro_scale = GYRO_FS_RST;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        src_idle_on = 1'b1;
        sink_idle_on = 1'b1;
        test_directed_frames();
        test_scale_extremes();
        test_output_backpressure();
        test_random_stream(220, 11'd16, 11'd2000);
        test_random_stream(220, 11'd1, 11'd2047);
        test_random_stream(160, 11'd8, 11'd500);
        // last stretch runs at full rate on both sides
        src_idle_on = 1'b0;
        sink_idle_on = 1'b0;
        test_random_stream(150, CFG_DATA_W'($urandom_range(1, 16)),
                           CFG_DATA_W'($urandom_range(1, 2000)));

        if (pending_results.size() != 0)
            report_mismatch($sformatf("%0d frame results never arrived", pending_results.size()));
        $display("covered %0d bytes and %0d frame results over ten full scale settings",
                 bytes_sent, results_seen);
        $display("clean results: angle %0d, imu %0d, other %0d, checksum %0d, bad id/length %0d",
                 status_seen[STAT_ANGLE], status_seen[STAT_IMU], status_seen[STAT_OTHER],
                 status_seen[STAT_CKSUM], status_seen[STAT_BADID]);
        if (err_count == 0)
            $display("imu_serial_frame_parser test passed");
        else
            $display("imu_serial_frame_parser test failed");
        $finish;
    end

endmodule
